### hw/rtl/lfps_pkg.sv
package lfps_pkg;

    // Fraction bits of the unsigned gains.
    localparam int GAIN_FRAC_BITS = 8;

    // Field widths.
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 8;
    localparam int LIMIT_W  = 10;
    localparam int ERR_W    = 3;
    localparam int INTEG_W  = 11;
    localparam int DIFF_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // The weighted sum stays below 65535 * (3 + 1023 + 6) in magnitude.
    localparam int SUM_W  = 28;
    localparam int CORR_W = SUM_W - GAIN_FRAC_BITS;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd5;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd15360;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd6400;
    localparam logic [DUTY_W-1:0]  BASE_DUTY_RST = 8'd180;
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RST  = 8'd255;
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 10'd100;

    // Sensor patterns, ordered left, center, right.
    localparam logic [2:0] PAT_LOST         = 3'b000;
    localparam logic [2:0] PAT_CENTER       = 3'b010;
    localparam logic [2:0] PAT_LEFT_CENTER  = 3'b110;
    localparam logic [2:0] PAT_LEFT         = 3'b100;
    localparam logic [2:0] PAT_RIGHT_CENTER = 3'b011;
    localparam logic [2:0] PAT_RIGHT        = 3'b001;

    // Error values.
    localparam logic signed [ERR_W-1:0] ERR_ZERO      = 3'sd0;
    localparam logic signed [ERR_W-1:0] ERR_LEFT_1    = -3'sd1;
    localparam logic signed [ERR_W-1:0] ERR_LEFT_2    = -3'sd2;
    localparam logic signed [ERR_W-1:0] ERR_RIGHT_1   = 3'sd1;
    localparam logic signed [ERR_W-1:0] ERR_RIGHT_2   = 3'sd2;
    localparam logic signed [ERR_W-1:0] ERR_LOST_LEFT  = -3'sd3;
    localparam logic signed [ERR_W-1:0] ERR_LOST_RIGHT = 3'sd3;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [DUTY_W-1:0]  base_duty;
        logic [DUTY_W-1:0]  max_duty;
        logic [LIMIT_W-1:0] integral_limit;
    } cfg_t;

    // Error terms handed from the error stage to the control law.
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
    } err_terms_t;

endpackage

### hw/rtl/lfps_cfg.sv
module lfps_cfg
    import lfps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAIN_P:    cfg_next.gain_p = cfg_data;
                CFG_GAIN_I:    cfg_next.gain_i = cfg_data;
                CFG_GAIN_D:    cfg_next.gain_d = cfg_data;
                CFG_BASE_DUTY: cfg_next.base_duty = cfg_data[DUTY_W-1:0];
                CFG_MAX_DUTY:  cfg_next.max_duty = cfg_data[DUTY_W-1:0];
                CFG_INT_LIMIT: cfg_next.integral_limit = cfg_data[LIMIT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.base_duty      <= BASE_DUTY_RST;
            cfg_reg.max_duty       <= MAX_DUTY_RST;
            cfg_reg.integral_limit <= INT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/lfps_err.sv
module lfps_err
    import lfps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [2:0]         pattern,
    input  logic [LIMIT_W-1:0] integral_limit,
    output err_terms_t         terms
);

    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [ERR_W-1:0]   last_error_next;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [INTEG_W-1:0] integral_next;

    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W:0]   lim_pos;
    logic signed [INTEG_W:0]   lim_neg;
    logic signed [INTEG_W-1:0] integ_clamped;

    always_comb
    begin
        case (pattern)
            PAT_CENTER:       err = ERR_ZERO;
            PAT_LEFT_CENTER:  err = ERR_LEFT_1;
            PAT_LEFT:         err = ERR_LEFT_2;
            PAT_RIGHT_CENTER: err = ERR_RIGHT_1;
            PAT_RIGHT:        err = ERR_RIGHT_2;
            PAT_LOST:
            begin
                if (last_error_reg < ERR_ZERO)
                    err = ERR_LOST_LEFT;
                else if (last_error_reg > ERR_ZERO)
                    err = ERR_LOST_RIGHT;
                else
                    err = ERR_ZERO;
            end
            default:          err = last_error_reg;
        endcase
    end

    // Running sum with a symmetric clamp against the current limit.
    always_comb
    begin
        integ_sum = {integral_reg[INTEG_W-1], integral_reg}
                  + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
        lim_pos   = $signed({2'b00, integral_limit});
        lim_neg   = -lim_pos;
        if (integ_sum > lim_pos)
            integ_clamped = lim_pos[INTEG_W-1:0];
        else if (integ_sum < lim_neg)
            integ_clamped = lim_neg[INTEG_W-1:0];
        else
            integ_clamped = integ_sum[INTEG_W-1:0];
    end

    assign terms.err   = err;
    assign terms.integ = integ_clamped;
    assign terms.diff  = {err[ERR_W-1], err} - {last_error_reg[ERR_W-1], last_error_reg};

    assign last_error_next = advance ? err : last_error_reg;
    assign integral_next   = advance ? integ_clamped : integral_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            integral_reg   <= '0;
        end
        else
        begin
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
        end
    end

endmodule

### hw/rtl/lfps_law.sv
module lfps_law
    import lfps_pkg::*;
(
    input  cfg_t              cfg,
    input  err_terms_t        terms,
    output logic [DUTY_W-1:0] left_duty,
    output logic [DUTY_W-1:0] right_duty
);

    logic signed [SUM_W-1:0]  prod_p;
    logic signed [SUM_W-1:0]  prod_i;
    logic signed [SUM_W-1:0]  prod_d;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  biased;
    logic signed [CORR_W-1:0] corr;
    logic signed [CORR_W:0]   base_ext;
    logic signed [CORR_W:0]   max_ext;
    logic signed [CORR_W:0]   left_raw;
    logic signed [CORR_W:0]   right_raw;

    function automatic logic [DUTY_W-1:0] sat_duty(
        input logic signed [CORR_W:0] v,
        input logic signed [CORR_W:0] vmax
    );
        logic [DUTY_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > vmax)
            res = vmax[DUTY_W-1:0];
        else
            res = v[DUTY_W-1:0];
        return res;
    endfunction

    assign prod_p = $signed({1'b0, cfg.gain_p}) * terms.err;
    assign prod_i = $signed({1'b0, cfg.gain_i}) * terms.integ;
    assign prod_d = $signed({1'b0, cfg.gain_d}) * terms.diff;
    assign sum    = prod_p + prod_i + prod_d;

    // Truncation toward zero: bias negative sums before the arithmetic shift.
    assign biased = sum[SUM_W-1]
                  ? sum + $signed({{(SUM_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}})
                  : sum;
    assign corr   = biased[SUM_W-1:GAIN_FRAC_BITS];

    assign base_ext  = $signed({{(CORR_W+1-DUTY_W){1'b0}}, cfg.base_duty});
    assign max_ext   = $signed({{(CORR_W+1-DUTY_W){1'b0}}, cfg.max_duty});
    assign left_raw  = base_ext + {corr[CORR_W-1], corr};
    assign right_raw = base_ext - {corr[CORR_W-1], corr};

    assign left_duty  = sat_duty(left_raw, max_ext);
    assign right_duty = sat_duty(right_raw, max_ext);

endmodule

### hw/rtl/line_follow_pid_steering.sv
// Channel  Handshake               Payload
// -------  ----------------------  ------------------------------------------
// in       in_valid / in_stall     sense_left, sense_center, sense_right
// out      out_valid / out_stall   left_duty, right_duty, steer_error
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A sample waits in the input register while the error, PID and saturation
// logic forms its result; the result register takes it as the sample leaves.
// One transaction per cycle is sustained while out_stall is low, paced by the
// feedback of last error and integral. Reset clears all control state and
// loads the register defaults. An output stall holds the result and backs up
// into the input register, so in_stall rises only when both stages are full.
module line_follow_pid_steering
    import lfps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  sense_left,
    input  logic                  sense_center,
    input  logic                  sense_right,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     left_duty,
    output logic [DUTY_W-1:0]     right_duty,
    output logic signed [ERR_W-1:0] steer_error,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    err_terms_t terms;

    // Input stage.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [2:0] pattern_reg;
    logic [2:0] pattern_next;

    // Result stage.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DUTY_W-1:0]       left_reg;
    logic [DUTY_W-1:0]       left_next;
    logic [DUTY_W-1:0]       right_reg;
    logic [DUTY_W-1:0]       right_next;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;

    logic [DUTY_W-1:0] left_calc;
    logic [DUTY_W-1:0] right_calc;
    logic              out_free;
    logic              advance;
    logic              in_take;

    lfps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The error state moves forward only when a sample leaves the input stage.
    lfps_err u_err (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .pattern        (pattern_reg),
        .integral_limit (cfg.integral_limit),
        .terms          (terms)
    );

    lfps_law u_law (
        .cfg        (cfg),
        .terms      (terms),
        .left_duty  (left_calc),
        .right_duty (right_calc)
    );

    // The result register is free when empty or when its transaction completes.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        pattern_next  = pattern_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            pattern_next  = {sense_left, sense_center, sense_right};
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        err_next       = err_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            left_next      = left_calc;
            right_next     = right_calc;
            err_next       = terms.err;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        err_reg     <= err_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_duty   = left_reg;
    assign right_duty  = right_reg;
    assign steer_error = err_reg;

endmodule

### tb/sv/tb_line_follow_pid_steering.sv
`timescale 1ns / 1ps

// Self-checking bench for the line-following PID steering block.
//
// Every sensor sample that the block accepts is run through a behavioral
// copy of the steering law inside the scoreboard. The copy keeps its own
// last error, clamped integral and register set, and it queues one expected
// duty pair with its error per sample. Every result that leaves the block is
// compared field by field with the oldest queued expectation.
//
// Register writes happen only while the block is idle. That means after
// reset, or after every expected result has come back. The run steps
// through the reset defaults, the all-ones and all-zero extremes, a unit-gain
// setting and several random settings.
module tb_line_follow_pid_steering;
    import lfps_pkg::*;

    // Sensor patterns that the steering table does not list. The block must
    // repeat the previous error for them.
    localparam logic [2:0] PAT_OUTER_PAIR = 3'b101;
    localparam logic [2:0] PAT_ALL_ON     = 3'b111;

    // A long receiver hold-off, and the watchdog limit on cycles in which no
    // transaction of any kind completes. The limit leaves ample margin over
    // the hold-off and over the longest random gaps.
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef enum {TRACK_WALK, TRACK_HOLD, TRACK_LOST, TRACK_NOISE} track_mode_t;

    // Scoreboard with an embedded model of the steering law.
    class steer_scoreboard;
        typedef struct {
            logic [DUTY_W-1:0]        left_duty;
            logic [DUTY_W-1:0]        right_duty;
            logic signed [ERR_W-1:0]  steer_error;
        } duty_result_t;

        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [DUTY_W-1:0]         base_duty;
        logic [DUTY_W-1:0]         max_duty;
        logic [LIMIT_W-1:0]        integral_limit;
        logic signed [ERR_W-1:0]   last_err;
        logic signed [INTEG_W-1:0] err_integral;
        duty_result_t              expected_duties[$];
        int                        mismatches;
        int                        samples;
        int                        lost_ticks;
        int                        clamp_hits;

        function new();
            gain_p         = GAIN_P_RST;
            gain_i         = GAIN_I_RST;
            gain_d         = GAIN_D_RST;
            base_duty      = BASE_DUTY_RST;
            max_duty       = MAX_DUTY_RST;
            integral_limit = INT_LIMIT_RST;
            last_err       = ERR_ZERO;
            err_integral   = '0;
            mismatches     = 0;
            samples        = 0;
            lost_ticks     = 0;
            clamp_hits     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_P:    gain_p = data;
                CFG_GAIN_I:    gain_i = data;
                CFG_GAIN_D:    gain_d = data;
                CFG_BASE_DUTY: base_duty = data[DUTY_W-1:0];
                CFG_MAX_DUTY:  max_duty = data[DUTY_W-1:0];
                CFG_INT_LIMIT: integral_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [ERR_W-1:0] sensor_error(logic [2:0] pattern);
            case (pattern)
                PAT_CENTER:       return ERR_ZERO;
                PAT_LEFT_CENTER:  return ERR_LEFT_1;
                PAT_LEFT:         return ERR_LEFT_2;
                PAT_RIGHT_CENTER: return ERR_RIGHT_1;
                PAT_RIGHT:        return ERR_RIGHT_2;
                PAT_LOST:
                begin
                    if (last_err < 0)
                        return ERR_LOST_LEFT;
                    if (last_err > 0)
                        return ERR_LOST_RIGHT;
                    return ERR_ZERO;
                end
                default:          return last_err;
            endcase
        endfunction

        function logic [DUTY_W-1:0] clip_duty(longint value);
            if (value < 0)
                return '0;
            if (value > longint'(max_duty))
                return max_duty;
            return value[DUTY_W-1:0];
        endfunction

        // Steering law for one accepted sample; queues the expected result.
        function void note_sample(logic l, logic c, logic r);
            logic signed [ERR_W-1:0] err;
            int                      err_val;
            int                      lim;
            int                      acc;
            int                      diff;
            longint                  sum;
            longint                  mag;
            longint                  corr;
            duty_result_t            res;

            err     = sensor_error({l, c, r});
            err_val = err;
            lim     = int'(integral_limit);
            acc     = int'(err_integral) + err_val;
            diff    = err_val - int'(last_err);
            if (acc > lim)
            begin
                acc = lim;
                clamp_hits++;
            end
            if (acc < -lim)
            begin
                acc = -lim;
                clamp_hits++;
            end

            sum = longint'(gain_p) * err_val + longint'(gain_i) * acc
                + longint'(gain_d) * diff;
            // The fixed-point correction truncates toward zero.
            mag  = (sum < 0) ? -sum : sum;
            mag  = mag >> GAIN_FRAC_BITS;
            corr = (sum < 0) ? -mag : mag;

            res.left_duty   = clip_duty(longint'(base_duty) + corr);
            res.right_duty  = clip_duty(longint'(base_duty) - corr);
            res.steer_error = err;
            expected_duties.push_back(res);

            if (err == ERR_LOST_LEFT || err == ERR_LOST_RIGHT)
                lost_ticks++;
            samples++;
            err_integral = acc[INTEG_W-1:0];
            last_err     = err;
        endfunction

        function void check_result(logic [DUTY_W-1:0] ld, logic [DUTY_W-1:0] rd,
                                   logic signed [ERR_W-1:0] se);
            duty_result_t res;

            if (expected_duties.size() == 0)
            begin
                $error("duty result arrived with no sample outstanding");
                mismatches++;
                return;
            end
            res = expected_duties.pop_front();
            if (ld !== res.left_duty)
            begin
                $error("left_duty: expected %0d, got %0d", res.left_duty, ld);
                mismatches++;
            end
            if (rd !== res.right_duty)
            begin
                $error("right_duty: expected %0d, got %0d", res.right_duty, rd);
                mismatches++;
            end
            if (se !== res.steer_error)
            begin
                $error("steer_error: expected %0d, got %0d", res.steer_error, se);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_duties.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    sense_left;
    logic                    sense_center;
    logic                    sense_right;
    logic                    out_valid;
    logic                    out_stall;
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic signed [ERR_W-1:0] steer_error;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    steer_scoreboard sb = new();

    // Flags and counters used by the sender and the receiver process.
    bit          stall_on;
    bit          hold_req;
    int          holds_done;
    int          settings_applied;

    // State of the random track generator.
    track_mode_t track_mode;
    int          track_pos;
    int          track_run;
    logic [2:0]  track_held;

    logic [2:0]  directed_pats [0:21];

    line_follow_pid_steering DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sense_left   (sense_left),
        .sense_center (sense_center),
        .sense_right  (sense_right),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_duty    (left_duty),
        .right_duty   (right_duty),
        .steer_error  (steer_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Monitor. It samples at the rising edge, where every input was set up at
    // the falling edge before. The order of events within the step does not
    // matter. A sample accepted at this edge cannot leave the block at the
    // same edge, so the result is checked before the sample is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(left_duty, right_duty, steer_error);
            if (in_valid && !in_stall)
                sb.note_sample(sense_left, sense_center, sense_right);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog. It ends the run after a long stretch in which no
    // transaction completes on any channel.
    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction completed for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_line_follow_pid_steering NOT OK");
        $finish;
    end

    // Receiver. It stalls in random bursts while stall_on is set. On request
    // it holds off for one long stretch so that both pipeline stages fill and
    // the block has to stall its input.
    initial
    begin : receiver
        int burst;

        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                holds_done++;
            end
            else if (!stall_on || $urandom_range(3, 0) != 0)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                burst = $urandom_range(10, 1);
                out_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
        end
    end

    // Offers one sample and waits for the block to take it. The valid line
    // stays high, and the caller lowers it with end_samples or a gap.
    task automatic send_sample(logic [2:0] pattern);
        @(negedge clk);
        in_valid     <= 1'b1;
        sense_left   <= pattern[2];
        sense_center <= pattern[1];
        sense_right  <= pattern[0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic end_samples();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Loads a full register set once the block has gone idle. The pipeline
    // is empty as soon as the last result has left, and the task lets quiet
    // cycles pass before the writes.
    task automatic apply_setting(logic [CFG_DATA_W-1:0] gp, logic [CFG_DATA_W-1:0] gi,
                                 logic [CFG_DATA_W-1:0] gd, logic [CFG_DATA_W-1:0] base,
                                 logic [CFG_DATA_W-1:0] maxd, logic [CFG_DATA_W-1:0] lim);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_BASE_DUTY, base);
        write_reg(CFG_MAX_DUTY, maxd);
        write_reg(CFG_INT_LIMIT, lim);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // A modest setting keeps most duties off the rails, so the arithmetic
    // itself gets checked. A raw setting fills all 16 data bits, including
    // the ones that the narrow registers drop.
    task automatic apply_random_setting(bit modest);
        if (modest)
            apply_setting(16'($urandom_range(4095, 0)), 16'($urandom_range(511, 0)),
                          16'($urandom_range(4095, 0)), 16'($urandom_range(200, 60)),
                          16'($urandom_range(255, 150)), 16'($urandom_range(63, 0)));
        else
            apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [2:0] position_pattern(int pos);
        case (pos)
            -2:      return PAT_LEFT;
            -1:      return PAT_LEFT_CENTER;
            1:       return PAT_RIGHT_CENTER;
            2:       return PAT_RIGHT;
            default: return PAT_CENTER;
        endcase
    endfunction

    // Random track. A line position mostly drifts one step at a time.
    // Runs of one reading drive the integral into its clamp, line-lost runs
    // follow the last drift, and some stretches are raw sensor noise.
    function automatic logic [2:0] next_pattern();
        int pick;

        if (track_run == 0)
        begin
            pick      = $urandom_range(9, 0);
            track_run = $urandom_range(12, 1);
            if (pick < 6)
                track_mode = TRACK_WALK;
            else if (pick < 8)
            begin
                track_mode = TRACK_HOLD;
                track_held = position_pattern($urandom_range(4, 0) - 2);
            end
            else if (pick == 8)
                track_mode = TRACK_LOST;
            else
                track_mode = TRACK_NOISE;
        end
        track_run--;
        case (track_mode)
            TRACK_WALK:
            begin
                track_pos = track_pos + $urandom_range(2, 0) - 1;
                if (track_pos > 2)
                    track_pos = 2;
                if (track_pos < -2)
                    track_pos = -2;
                return position_pattern(track_pos);
            end
            TRACK_HOLD: return track_held;
            TRACK_LOST: return PAT_LOST;
            default:    return 3'($urandom_range(7, 0));
        endcase
    endfunction

    // Random samples. When idling is allowed, gaps on the sender and stalls
    // on the receiver are switched on or off every 25 samples. That leaves
    // quiet stretches between the busy ones.
    task automatic run_track(int count, bit idle_ok);
        bit gaps_on;

        gaps_on = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
            begin
                gaps_on  = idle_ok && ($urandom_range(2, 0) != 0);
                stall_on = idle_ok && ($urandom_range(2, 0) != 0);
            end
            send_sample(next_pattern());
            if (gaps_on && $urandom_range(3, 0) == 0)
                sender_gap($urandom_range(10, 1));
        end
        end_samples();
    endtask

    // Directed walk through every table entry. It covers a lost line after
    // a zero, a negative and a positive error, a repeated lost line, both
    // unlisted patterns, and the largest jumps of the error difference.
    task automatic run_directed();
        directed_pats = '{PAT_LOST, PAT_CENTER, PAT_LEFT_CENTER, PAT_LOST, PAT_LOST,
                          PAT_OUTER_PAIR, PAT_RIGHT_CENTER, PAT_RIGHT, PAT_LOST,
                          PAT_ALL_ON, PAT_LEFT, PAT_OUTER_PAIR, PAT_CENTER, PAT_LOST,
                          PAT_ALL_ON, PAT_RIGHT, PAT_LEFT, PAT_RIGHT, PAT_LEFT,
                          PAT_LOST, PAT_RIGHT, PAT_LOST};
        stall_on = 1'b1;
        foreach (directed_pats[i])
        begin
            send_sample(directed_pats[i]);
            if ($urandom_range(2, 0) == 0)
                sender_gap($urandom_range(10, 1));
        end
        end_samples();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sense_left   = 1'b0;
        sense_center = 1'b0;
        sense_right  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_GAIN_P;
        cfg_data     = '0;
        stall_on     = 1'b0;
        hold_req     = 1'b0;
        holds_done   = 0;
        settings_applied = 0;
        track_mode   = TRACK_WALK;
        track_pos    = 0;
        track_run    = 0;
        track_held   = PAT_CENTER;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults straight out of reset.
        run_directed();
        run_track(160, 1'b1);

        // All ones. The gains are at their maximum, the duties have no
        // headroom, and the integral limit is as wide as the register
        // allows.
        apply_setting('1, '1, '1, '1, '1, '1);
        run_directed();
        run_track(160, 1'b1);

        // All zero. The integral is pinned at zero and both duties stay at
        // zero.
        apply_setting('0, '0, '0, '0, '0, '0);
        run_track(140, 1'b1);

        // Unit proportional gain with a tight integral clamp. Writes to the
        // two unused register indexes must leave this setting alone.
        apply_setting(16'h0100, 16'h0080, 16'h0200, 16'd128, 16'd200, 16'd5);
        write_reg(3'(CFG_INT_LIMIT + 1), 16'($urandom));
        write_reg(3'(CFG_INT_LIMIT + 2), 16'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        run_track(180, 1'b1);

        // The receiver holds off for a long stretch while the sender keeps
        // offering samples back to back. The block fills and must stall
        // its input.
        apply_random_setting(1'b1);
        hold_req = 1'b1;
        run_track(40, 1'b0);
        run_track(160, 1'b1);

        // Mid-phase the sender stops until every result is back, then
        // carries on with the same setting and state.
        apply_random_setting(1'b0);
        run_track(100, 1'b1);
        wait_drained();
        run_track(100, 1'b1);

        apply_random_setting(1'b1);
        run_track(180, 1'b1);
        apply_random_setting(1'b0);
        run_track(180, 1'b1);

        // Last stretch at full rate with no idling on either side.
        apply_random_setting(1'b1);
        run_track(180, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Checked %0d sensor samples over %0d register settings plus the defaults.",
                 sb.samples, settings_applied);
        $display("Line lost on %0d ticks, integral clamped %0d times, %0d long hold-off(s).",
                 sb.lost_ticks, sb.clamp_hits, holds_done);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_line_follow_pid_steering OK");
        else
            $display("tb_line_follow_pid_steering NOT OK");
        $finish;
    end

endmodule
